/* rtl/core/wav_header_parser_defines.svh */
// Assertion macros used by the parser core RTL.
`ifndef WAV_HEADER_PARSER_DEFINES_SVH
`define WAV_HEADER_PARSER_DEFINES_SVH

`ifndef SYNTH
// Implication checked at every edge outside reset.
`define WAVHP_ASSERT(lbl, clk_i, rstn_i, prop, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) prop) else $error(msg);
// Condition that must never hold outside reset.
`define WAVHP_NEVER(lbl, clk_i, rstn_i, cond, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) !(cond)) else $error(msg);
`else
`define WAVHP_ASSERT(lbl, clk_i, rstn_i, prop, msg)
`define WAVHP_NEVER(lbl, clk_i, rstn_i, cond, msg)
`endif

`endif

/* rtl/core/wavhp_pkg.sv */
// Shared constants and types of the WAV header parser.
`timescale 1ns / 1ps
package wavhp_pkg;

	localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
	localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
	localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
	localparam logic [31:0] TAG_DATA = 32'h6461_7461;
	localparam logic [31:0] FMT_BODY_LEN = 32'd16;
	localparam logic [15:0] PCM_CODE = 16'd1;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_BAD_RIFF  = 3'd1;
	localparam logic [2:0] ST_BAD_WAVE  = 3'd2;
	localparam logic [2:0] ST_FMT_SMALL = 3'd3;
	localparam logic [2:0] ST_TRUNC     = 3'd4;
	localparam logic [2:0] ST_NO_FMT    = 3'd5;
	localparam logic [2:0] ST_NOT_PCM   = 3'd6;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] audio_format;
		logic [15:0] channel_count;
		logic [31:0] rate_hz;
		logic [15:0] sample_width;
		logic [31:0] data_size;
	} result_t;

	// handshake from parser core into the output register
	typedef struct packed {
		logic    valid;
		result_t res;
	} res_msg_t;

endpackage

/* rtl/core/wavhp_core.sv */
// Input stage register and header parse state machine.
`timescale 1ns / 1ps
`include "wav_header_parser_defines.svh"
module wavhp_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [7:0]          data_byte,
	input  logic                file_start,
	input  logic                file_end,
	input  logic                res_ready,
	output wavhp_pkg::res_msg_t res_msg
);

	typedef enum logic [2:0] {
		PH_IDLE, PH_RIFF, PH_CHUNK, PH_FMT, PH_SKIP, PH_DONE
	} phase_t;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        start_s1;
	logic        end_s1;
	logic        adv;

	phase_t      phase_q, phase_d;
	logic [3:0]  pos_q, pos_d;
	logic [31:0] tag_q, tag_d;
	logic [31:0] clen_q, clen_d;
	logic [31:0] skip_q, skip_d;
	logic        fseen_q, fseen_d;
	logic [15:0] fcode_q, fcode_d;
	logic [15:0] chan_q, chan_d;
	logic [31:0] rate_q, rate_d;
	logic [15:0] bits_q, bits_d;
	logic        emit;
	logic [2:0]  emit_st;
	logic [31:0] emit_size;

	assign adv      = valid_s1 && res_ready;
	assign in_stall = valid_s1 && !res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1  <= data_byte;
			start_s1 <= file_start;
			end_s1   <= file_end;
		end
	end

	always_comb begin
		phase_d   = phase_q;
		pos_d     = pos_q;
		tag_d     = tag_q;
		clen_d    = clen_q;
		skip_d    = skip_q;
		fseen_d   = fseen_q;
		fcode_d   = fcode_q;
		chan_d    = chan_q;
		rate_d    = rate_q;
		bits_d    = bits_q;
		emit      = 1'b0;
		emit_st   = wavhp_pkg::ST_OK;
		emit_size = 32'd0;

		if (start_s1) begin
			phase_d = PH_RIFF;
			pos_d   = 4'd0;
			tag_d   = 32'd0;
			clen_d  = 32'd0;
			skip_d  = 32'd0;
			fseen_d = 1'b0;
			fcode_d = 16'd0;
			chan_d  = 16'd0;
			rate_d  = 32'd0;
			bits_d  = 16'd0;
		end

		case (phase_d)
			PH_RIFF: begin
				tag_d = {tag_d[23:0], byte_s1};
				if (pos_d == 4'd3 && tag_d != wavhp_pkg::TAG_RIFF) begin
					emit    = 1'b1;
					emit_st = wavhp_pkg::ST_BAD_RIFF;
				end else if (pos_d == 4'd11) begin
					if (tag_d != wavhp_pkg::TAG_WAVE) begin
						emit    = 1'b1;
						emit_st = wavhp_pkg::ST_BAD_WAVE;
					end else begin
						phase_d = PH_CHUNK;
						pos_d   = 4'd0;
					end
				end else begin
					pos_d = pos_d + 4'd1;
				end
			end
			PH_CHUNK: begin
				if (pos_d < 4'd4) begin
					tag_d = {tag_d[23:0], byte_s1};
				end else begin
					clen_d = {byte_s1, clen_d[31:8]};
				end
				if (pos_d == 4'd7) begin
					pos_d = 4'd0;
					if (tag_d == wavhp_pkg::TAG_FMT) begin
						if (clen_d < wavhp_pkg::FMT_BODY_LEN) begin
							emit    = 1'b1;
							emit_st = wavhp_pkg::ST_FMT_SMALL;
						end else begin
							phase_d = PH_FMT;
						end
					end else if (tag_d == wavhp_pkg::TAG_DATA) begin
						emit      = 1'b1;
						emit_size = clen_d;
						if (!fseen_d) begin
							emit_st = wavhp_pkg::ST_NO_FMT;
						end else if (fcode_d != wavhp_pkg::PCM_CODE) begin
							emit_st = wavhp_pkg::ST_NOT_PCM;
						end else begin
							emit_st = wavhp_pkg::ST_OK;
						end
					end else if (clen_d != 32'd0) begin
						skip_d  = clen_d;
						phase_d = PH_SKIP;
					end
				end else begin
					pos_d = pos_d + 4'd1;
				end
			end
			PH_FMT: begin
				case (pos_d)
					4'd0:  fcode_d[7:0]   = byte_s1;
					4'd1:  fcode_d[15:8]  = byte_s1;
					4'd2:  chan_d[7:0]    = byte_s1;
					4'd3:  chan_d[15:8]   = byte_s1;
					4'd4:  rate_d[7:0]    = byte_s1;
					4'd5:  rate_d[15:8]   = byte_s1;
					4'd6:  rate_d[23:16]  = byte_s1;
					4'd7:  rate_d[31:24]  = byte_s1;
					4'd14: bits_d[7:0]    = byte_s1;
					4'd15: bits_d[15:8]   = byte_s1;
					default: ;
				endcase
				if (pos_d == 4'd15) begin
					fseen_d = 1'b1;
					skip_d  = clen_d - wavhp_pkg::FMT_BODY_LEN;
					pos_d   = 4'd0;
					phase_d = (clen_d == wavhp_pkg::FMT_BODY_LEN) ? PH_CHUNK : PH_SKIP;
				end else begin
					pos_d = pos_d + 4'd1;
				end
			end
			PH_SKIP: begin
				skip_d = skip_d - 32'd1;
				if (skip_d == 32'd0) begin
					phase_d = PH_CHUNK;
					pos_d   = 4'd0;
				end
			end
			default: ;
		endcase

		// end of file while still parsing, and this byte closed nothing
		if (!emit && end_s1 && (phase_d == PH_RIFF || phase_d == PH_CHUNK ||
				phase_d == PH_FMT || phase_d == PH_SKIP)) begin
			emit      = 1'b1;
			emit_st   = wavhp_pkg::ST_TRUNC;
			emit_size = 32'd0;
		end
		if (emit) begin
			phase_d = PH_DONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			pos_q   <= 4'd0;
			tag_q   <= 32'd0;
			clen_q  <= 32'd0;
			skip_q  <= 32'd0;
			fseen_q <= 1'b0;
			fcode_q <= 16'd0;
			chan_q  <= 16'd0;
			rate_q  <= 32'd0;
			bits_q  <= 16'd0;
		end else if (adv) begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			tag_q   <= tag_d;
			clen_q  <= clen_d;
			skip_q  <= skip_d;
			fseen_q <= fseen_d;
			fcode_q <= fcode_d;
			chan_q  <= chan_d;
			rate_q  <= rate_d;
			bits_q  <= bits_d;
		end
	end

	assign res_msg.valid             = adv && emit;
	assign res_msg.res.status        = emit_st;
	assign res_msg.res.audio_format  = fcode_d;
	assign res_msg.res.channel_count = chan_d;
	assign res_msg.res.rate_hz       = rate_d;
	assign res_msg.res.sample_width  = bits_d;
	assign res_msg.res.data_size     = emit_size;

	`WAVHP_ASSERT(a_emit_to_done, clk, arst_n, (adv && emit) |=> (phase_q == PH_DONE), "result did not end the parse")
	`WAVHP_NEVER(a_idle_silent, clk, arst_n, adv && !start_s1 && emit && (phase_q == PH_IDLE || phase_q == PH_DONE), "result from idle parser")
	`WAVHP_NEVER(a_chunk_pos, clk, arst_n, phase_q == PH_CHUNK && pos_q > 4'd7, "chunk header position overran")
	`WAVHP_NEVER(a_skip_nonzero, clk, arst_n, phase_q == PH_SKIP && skip_q == 32'd0, "skip entered with zero count")

endmodule

/* rtl/core/wavhp_out.sv */
// Result register between the parser core and the output channel.
`timescale 1ns / 1ps
module wavhp_out (
	input  logic                clk,
	input  logic                arst_n,
	input  wavhp_pkg::res_msg_t res_msg,
	output logic                res_ready,
	output logic                out_valid,
	input  logic                out_stall,
	output wavhp_pkg::result_t  res_out
);

	logic               valid_q;
	wavhp_pkg::result_t res_q;

	assign res_ready = !valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_ready) begin
			valid_q <= res_msg.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_msg.valid) begin
			res_q <= res_msg.res;
		end
	end

	assign out_valid = valid_q;
	assign res_out   = res_q;

endmodule

/* rtl/core/wav_header_parser.sv */
// Top level of the byte-serial RIFF/WAVE header parser.
`timescale 1ns / 1ps
// Takes one file byte per item (file_start on the first byte, file_end on the last
// available one) and returns one result when a data chunk header completes, when a
// tag or fmt check fails, or when the file ends early. Throughput is one byte per
// clock; a byte is held in the input stage register, where the parse state
// updates, and any result appears in the output register on the next cycle. The
// input stage holds only while a result waits stalled in the output register.
// Bytes after a result are ignored until the next file_start.
module wav_header_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        file_start,
	input  logic        file_end,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [15:0] audio_format,
	output logic [15:0] channel_count,
	output logic [31:0] rate_hz,
	output logic [15:0] sample_width,
	output logic [31:0] data_size
);

	wavhp_pkg::res_msg_t res_msg;
	wavhp_pkg::result_t  res_out;
	logic                res_ready;

	wavhp_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.data_byte  (data_byte),
		.file_start (file_start),
		.file_end   (file_end),
		.res_ready  (res_ready),
		.res_msg    (res_msg)
	);

	wavhp_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_msg   (res_msg),
		.res_ready (res_ready),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res_out   (res_out)
	);

	assign status        = res_out.status;
	assign audio_format  = res_out.audio_format;
	assign channel_count = res_out.channel_count;
	assign rate_hz       = res_out.rate_hz;
	assign sample_width  = res_out.sample_width;
	assign data_size     = res_out.data_size;

endmodule
